[design/sdas_pkg.sv]
// Shared types and constants for the SPI DSP access segmenter.
// Holds the request and response structs, the command and status codes and the state enum.
// No dependencies.
`default_nettype none

package sdas_pkg;

  localparam int unsigned MaxBurst   = 240;
  localparam int unsigned MaxRequest = 4096;
  localparam int unsigned MaxResults = 24;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned CountW = 13;
  localparam int unsigned LenW   = 8;
  localparam int unsigned IdxW   = $clog2(MaxResults);

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StReject = 2'd1,
    StEmpty  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CmdRd16    = 3'd0,
    CmdWr16    = 3'd1,
    CmdRd32    = 3'd2,
    CmdWr32    = 3'd3,
    CmdRdBurst = 3'd4,
    CmdWrBurst = 3'd5
  } cmd_e;

  typedef enum logic {
    SdasIdle,
    SdasRun
  } sdas_state_e;

  typedef struct packed {
    logic              func;
    logic [AddrW-1:0]  start_addr;
    logic [CountW-1:0] byte_count;
  } sdas_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [2:0]       cmd_code;
    logic [AddrW-1:0] seg_addr;
    logic [LenW-1:0]  seg_len;
    logic             last;
  } sdas_rsp_t;

endpackage

`default_nettype wire

[design/spi_dsp_access_segmenter.sv]
// SPI DSP access segmenter: splits one memory access request into bus transactions.
// One sequencer drives a shared size/advance step each cycle unless stalled; depends on sdas_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_req_i) takes one access request:
//   read or write, start address and byte count. Output channel (out_valid_o /
//   out_ready_i / out_rsp_o) gives one response per bus transaction, the final
//   one of a request flagged by last. A rejected (misaligned or oversized) or
//   empty request gives exactly one response with the matching status.
// Order and throughput:
//   The first response goes into the output register after the request is
//   loaded into the working registers. One response is produced per cycle
//   after that while the receiver takes them; a request gives at most 24
//   responses. The rate is set by the single size/advance step that all
//   transactions of a request go through, one per cycle.
// Stalls:
//   A response holds in the output register while out_ready_i is low; the
//   sequencer freezes until it is taken. A new request is taken only once the
//   final response of the previous one is in the output register.
// Reset:
//   rst_ni (async, active low) returns the sequencer to idle and drops out_valid_o.
`default_nettype none

module spi_dsp_access_segmenter (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire sdas_pkg::sdas_req_t in_req_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output sdas_pkg::sdas_rsp_t      out_rsp_o
);

  // Sequencer state
  sdas_pkg::sdas_state_e state_q, state_d;

  // Working registers of the current request
  logic                          rd_q;
  sdas_pkg::status_e             kind_q;
  logic [sdas_pkg::AddrW-1:0]    addr_q;
  logic [sdas_pkg::CountW-1:0]   remain_q;
  logic [sdas_pkg::IdxW-1:0]     idx_q;

  // Output register
  logic                          out_valid_q;
  sdas_pkg::sdas_rsp_t           out_q;

  logic                          in_fire;
  logic                          step_en;
  logic                          req_reject;
  logic                          req_empty;
  logic [sdas_pkg::CountW-1:0]   req_total;

  // Shared step unit signals
  sdas_pkg::cmd_e                rd_code;
  logic [sdas_pkg::LenW-1:0]     seg_len;
  logic [sdas_pkg::CountW-1:0]   burst_len;
  logic                          seg_last;
  sdas_pkg::sdas_rsp_t           seg_rsp;
  logic [2:0]                    align;

  assign in_fire = in_valid_i && in_ready_o;

  // Classify the incoming request; pad an odd write count by one byte.
  assign req_reject = in_req_i.start_addr[0]
                    || (in_req_i.func && in_req_i.byte_count[0])
                    || (in_req_i.byte_count > sdas_pkg::CountW'(sdas_pkg::MaxRequest));
  assign req_empty  = (in_req_i.byte_count == '0);
  assign req_total  = in_req_i.byte_count
                    + {{(sdas_pkg::CountW-1){1'b0}}, in_req_i.byte_count[0]};

  // Size pick for the transaction at addr_q with remain_q bytes left.
  assign align     = addr_q[2:0];
  assign burst_len = {remain_q[sdas_pkg::CountW-1:3], 3'b000};

  always_comb begin
    if (align == 3'd2 || align == 3'd6 || remain_q == sdas_pkg::CountW'(2)) begin
      rd_code = sdas_pkg::CmdRd16;
      seg_len = sdas_pkg::LenW'(2);
    end else if (align == 3'd4 || remain_q <= sdas_pkg::CountW'(6)) begin
      rd_code = sdas_pkg::CmdRd32;
      seg_len = sdas_pkg::LenW'(4);
    end else begin
      rd_code = sdas_pkg::CmdRdBurst;
      if (burst_len < sdas_pkg::CountW'(sdas_pkg::MaxBurst)) begin
        seg_len = burst_len[sdas_pkg::LenW-1:0];
      end else begin
        seg_len = sdas_pkg::LenW'(sdas_pkg::MaxBurst);
      end
    end
  end

  // Build the response for this step. Rejected and empty requests end at once;
  // a transaction ends the request when it covers what is left, or at the
  // response limit.
  always_comb begin
    seg_rsp = '0;
    seg_rsp.seg_addr = addr_q;
    if (kind_q != sdas_pkg::StOk) begin
      seg_rsp.status   = kind_q;
      seg_rsp.cmd_code = sdas_pkg::CmdRd16;
      seg_rsp.seg_len  = '0;
      seg_rsp.last     = 1'b1;
    end else begin
      seg_rsp.status   = sdas_pkg::StOk;
      seg_rsp.cmd_code = rd_q ? rd_code : (rd_code + 3'd1);
      seg_rsp.seg_len  = seg_len;
      seg_rsp.last     = seg_last;
    end
  end

  assign seg_last = (sdas_pkg::CountW'(seg_len) >= remain_q)
                 || (idx_q == sdas_pkg::IdxW'(sdas_pkg::MaxResults - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sdas_pkg::SdasIdle: begin
        if (in_valid_i) state_d = sdas_pkg::SdasRun;
      end
      sdas_pkg::SdasRun: begin
        if (step_en && seg_rsp.last) state_d = sdas_pkg::SdasIdle;
      end
      default: state_d = sdas_pkg::SdasIdle;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    step_en    = 1'b0;
    unique case (state_q)
      sdas_pkg::SdasIdle: in_ready_o = 1'b1;
      sdas_pkg::SdasRun:  step_en    = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        step_en    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdas_pkg::SdasIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (step_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers: load on accept, advance on each step.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q     <= in_req_i.func;
      addr_q   <= in_req_i.start_addr;
      remain_q <= req_total;
      idx_q    <= '0;
      if (req_reject) begin
        kind_q <= sdas_pkg::StReject;
      end else if (req_empty) begin
        kind_q <= sdas_pkg::StEmpty;
      end else begin
        kind_q <= sdas_pkg::StOk;
      end
    end else if (step_en) begin
      addr_q   <= addr_q + sdas_pkg::AddrW'(seg_len);
      remain_q <= remain_q - sdas_pkg::CountW'(seg_len);
      idx_q    <= idx_q + sdas_pkg::IdxW'(1);
    end
    if (step_en) begin
      out_q <= seg_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

[design/sdas_checker.sv]
// Port-level checker for spi_dsp_access_segmenter, attached by bind.
// Depends on sdas_pkg.
`default_nettype none

module sdas_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_valid_i,
  input wire                      in_ready_o,
  input wire sdas_pkg::sdas_req_t in_req_i,
  input wire                      out_valid_o,
  input wire                      out_ready_i,
  input wire sdas_pkg::sdas_rsp_t out_rsp_o
);

  // Hold a stalled response.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed or dropped");

  // Go busy after taking a request.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in flight");

  // Reject and empty responses end their request.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != sdas_pkg::StOk |-> out_rsp_o.last)
    else $error("error response without last");

  // Transactions move a nonzero even length at an even address.
  a_seg_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == sdas_pkg::StOk |->
      out_rsp_o.seg_len != '0 && !out_rsp_o.seg_len[0] && !out_rsp_o.seg_addr[0])
    else $error("malformed transaction");

  // No new request while a non-final response is pending.
  a_no_req_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.last |-> !in_ready_o)
    else $error("ready while request still in progress");

endmodule

bind spi_dsp_access_segmenter sdas_checker u_sdas_checker (.*);

`default_nettype wire

[verif/segment_checker.sv]
`timescale 1ns / 100ps
// Checker for the access segmenter: predicts the bus transactions of every accepted
// request and compares each accepted response against them in order.
// Depends on sdas_pkg for the request/response structs and the command and status codes.

module segment_checker
  import sdas_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_ready_i,
  input  sdas_req_t  in_req_i,
  input  wire        out_valid_i,
  input  wire        out_ready_i,
  input  sdas_rsp_t  out_rsp_i,
  output int         fail_count_o,
  output int         pending_o
);

  sdas_rsp_t expected_segments[$];
  int        mismatches = 0;
  int        outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  // Queue the transactions one request splits into.
  function automatic void predict_segments(input sdas_req_t req);
    sdas_rsp_t        seg;
    logic [AddrW-1:0] seg_addr;
    logic [2:0]       align;
    int unsigned      total;
    int unsigned      offset;
    int unsigned      remain;
    int unsigned      len;
    int unsigned      n;
    logic             done;
    cmd_e             cmd;

    seg = '0;
    seg.seg_addr = req.start_addr;
    seg.cmd_code = CmdRd16;
    seg.last     = 1'b1;
    if (req.start_addr[0] || (req.func && req.byte_count[0]) ||
        req.byte_count > MaxRequest) begin
      seg.status = StReject;
      expected_segments.push_back(seg);
      return;
    end
    if (req.byte_count == '0) begin
      seg.status = StEmpty;
      expected_segments.push_back(seg);
      return;
    end

    // Odd write counts are padded up to the next even byte.
    total  = 32'(req.byte_count) + 32'(req.byte_count[0]);
    offset = 0;
    n      = 0;
    done   = 1'b0;
    while (!done) begin
      seg_addr = req.start_addr + offset;
      align    = seg_addr[2:0];
      remain   = total - offset;
      if (align == 3'd2 || align == 3'd6 || remain == 2) begin
        len = 2;
        cmd = req.func ? CmdRd16 : CmdWr16;
      end else if (align == 3'd4 || remain <= 6) begin
        len = 4;
        cmd = req.func ? CmdRd32 : CmdWr32;
      end else begin
        len = remain & ~32'd7;
        if (len > MaxBurst) len = MaxBurst;
        cmd = req.func ? CmdRdBurst : CmdWrBurst;
      end
      offset += len;
      done = (offset >= total) || (n == MaxResults - 1);
      seg.status   = StOk;
      seg.cmd_code = cmd;
      seg.seg_addr = seg_addr;
      seg.seg_len  = len[LenW-1:0];
      seg.last     = done;
      expected_segments.push_back(seg);
      n++;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    sdas_rsp_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) predict_segments(in_req_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_segments.size() == 0) begin
          mismatches++;
          $display("%0t: response with none expected, expected none, actual %0h",
                   $time, out_rsp_i);
        end else begin
          want = expected_segments.pop_front();
          check_field("status", 32'(want.status), 32'(out_rsp_i.status));
          check_field("cmd_code", 32'(want.cmd_code), 32'(out_rsp_i.cmd_code));
          check_field("seg_addr", want.seg_addr, out_rsp_i.seg_addr);
          check_field("seg_len", 32'(want.seg_len), 32'(out_rsp_i.seg_len));
          check_field("last", 32'(want.last), 32'(out_rsp_i.last));
        end
      end
      outstanding = expected_segments.size();
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Top of the access segmenter testbench: clock, reset, request stimulus, response
// back-pressure, watchdog and verdict. Uses sdas_pkg, the segmenter and segment_checker.

module testbench;
  import sdas_pkg::*;

  // Cycles without any handshake before the run is declared hung. A request
  // waits at most one random sender gap plus its trip through the block, and each
  // response at most one random receiver stall: far beyond any legal quiet spell.
  localparam int IdleLimit = 3000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  sdas_req_t in_req;
  logic      out_valid;
  logic      out_ready;
  sdas_rsp_t out_rsp;
  int        fail_count;
  int        pending;

  // Sender runs back to back when set; toggled in stretches by the stimulus.
  logic steady_sender = 1'b0;
  int   idle_cycles   = 0;
  int   taken         = 0;

  spi_dsp_access_segmenter uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  segment_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_i   (out_rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one request after a random gap and hold it until accepted. Valid is
  // left high on return so a zero-gap follow-up request streams without a bubble;
  // drop it only when a gap comes next.
  task automatic send_request(input logic func, input logic [AddrW-1:0] addr,
                              input logic [CountW-1:0] count);
    sdas_req_t req;
    int        gap;
    req.func       = func;
    req.start_addr = addr;
    req.byte_count = count;
    gap = steady_sender ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every predicted response has been taken.
  task automatic drain_responses();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // Receiver: stall a random number of cycles before each response, except in
  // stretches where ready stays high so responses stream one per cycle.
  initial begin
    int gap;
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = (((taken / 60) % 3) == 1) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Watchdog: count cycles in which neither channel completes a handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int               kind;
    int               size_class;
    logic             func;
    logic [AddrW-1:0] addr;
    logic [CountW-1:0] count;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_req   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty requests, rejections, padding, every command size,
    // address wrap and field extremes. func 1 is a read, 0 a write.
    send_request(1'b1, 32'h0000_0000, 13'd0);     // empty read
    send_request(1'b0, 32'h0000_1000, 13'd0);     // empty write
    send_request(1'b0, 32'h0000_0003, 13'd0);     // odd address wins over empty
    send_request(1'b1, 32'hFFFF_FFFF, 13'd2);     // read, odd address
    send_request(1'b1, 32'h0000_0100, 13'd7);     // read, odd count
    send_request(1'b0, 32'h0000_0101, 13'd8);     // write, odd address
    send_request(1'b0, 32'h0000_0200, 13'd1);     // odd write count, pads to one wr16
    send_request(1'b0, 32'h0000_0206, 13'd13);    // pad plus wr16, burst, wr32
    send_request(1'b1, 32'h0000_0000, 13'd4097);  // oversized
    send_request(1'b0, 32'h0000_0010, 13'h1FFF);  // all count bits set, oversized
    send_request(1'b1, 32'h0000_0000, 13'd4096);  // largest read, many bursts
    send_request(1'b0, 32'hFFFF_FFF0, 13'd4096);  // largest write across address wrap
    send_request(1'b1, 32'hFFFF_FFFE, 13'd2);     // top of address space, rd16
    send_request(1'b1, 32'h0000_0004, 13'd4);     // rd32 at alignment 4
    send_request(1'b0, 32'h0000_0004, 13'd6);     // wr32 then wr16
    send_request(1'b1, 32'h0000_0008, 13'd6);     // short tail: rd32 then rd16
    send_request(1'b1, 32'h0000_0002, 13'd250);   // rd16, rd32, capped burst, rd32
    send_request(1'b0, 32'h0000_0000, 13'd240);   // exactly one full burst
    send_request(1'b0, 32'h0000_0008, 13'd248);   // capped burst then 8-byte burst
    send_request(1'b1, 32'h0000_0006, 13'd16);    // alignment 6 start
    send_request(1'b0, 32'h0000_0000, 13'd4095);  // odd write count at the limit
    send_request(1'b1, 32'hAAAA_5554, 13'd8190);  // oversized even read
    send_request(1'b0, 32'h5555_AAAA, 13'd4096);
    drain_responses();

    // Random: mostly well-formed requests with random address and size, some
    // empty ones, and the rest unconstrained noise over all field values.
    for (int i = 0; i < 380; i++) begin
      steady_sender = ((i / 40) % 3) == 2;
      kind = $urandom_range(0, 99);
      func = 1'($urandom_range(0, 1));
      addr = $urandom();
      if (kind < 70) begin
        addr[0]    = 1'b0;
        size_class = $urandom_range(0, 9);
        if (size_class < 6)       count = CountW'($urandom_range(1, 40));
        else if (size_class < 8)  count = CountW'($urandom_range(1, 300));
        else if (size_class == 8) count = CountW'($urandom_range(1, MaxRequest));
        else count = CountW'($urandom_range(MaxRequest - 6, MaxRequest));
        // Reads need an even count to get past the alignment check.
        if (func) begin
          count[0] = 1'b0;
          if (count == '0) count = 13'd2;
        end
      end else if (kind < 78) begin
        addr[0] = 1'b0;
        count   = '0;
      end else begin
        count = CountW'($urandom_range(0, 8191));
      end
      send_request(func, addr, count);
      if (i == 190) drain_responses();
    end

    drain_responses();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
design/sdas_pkg.sv
design/spi_dsp_access_segmenter.sv
design/sdas_checker.sv
verif/segment_checker.sv
verif/testbench.sv
